@@ design/bsc_pkg.sv @@
package bsc_pkg;

    // Input item commands
    localparam logic [2:0] CMD_LOAD_AVAIL = 3'd0;
    localparam logic [2:0] CMD_LOAD_MAX   = 3'd1;
    localparam logic [2:0] CMD_LOAD_ALLOC = 3'd2;
    localparam logic [2:0] CMD_LOAD_NEED  = 3'd3;
    localparam logic [2:0] CMD_CHECK      = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_SAFE   = 2'd0;
    localparam logic [1:0] ST_UNSAFE = 2'd1;
    localparam logic [1:0] ST_INCONS = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PROCESS_COUNT  = 1'b0;
    localparam logic CFG_RESOURCE_COUNT = 1'b1;

    localparam int CFG_DATA_W = 5;
    localparam int VALUE_W    = 16;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  process_index;
        logic [2:0]  resource_index;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] process_id;
        logic       last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       mem_rd;
        logic       work_init;
        logic       work_add;
        logic       order_wr;
        logic       emit;
        logic [1:0] emit_status;
        logic       emit_last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mismatch;
        logic fits;
    } t_dp_stat;

endpackage

@@ design/bsc_datapath.sv @@
module bsc_datapath #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
    localparam int RCW = $clog2(MAX_RESOURCES + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bsc_pkg::t_in_item                    i_item,
    input  bsc_pkg::t_dp_cmd                     i_cmd,
    input  logic [PW-1:0]                        i_p_idx,
    input  logic [RW-1:0]                        i_r_idx,
    input  logic [PW-1:0]                        i_slot,
    input  logic [RCW-1:0]                       i_nr,
    output bsc_pkg::t_dp_stat                    o_stat,
    output logic                                 o_strobe,
    output bsc_pkg::t_out_item                   o_result
);

    localparam int WW    = bsc_pkg::VALUE_W + $clog2(MAX_PROCESSES + 1);
    localparam int DEPTH = 2 ** (PW + RW);
    localparam int VW    = bsc_pkg::VALUE_W;

    logic [VW-1:0] r_max_mem   [DEPTH];
    logic [VW-1:0] r_alloc_mem [DEPTH];
    logic [VW-1:0] r_need_mem  [DEPTH];
    logic [VW-1:0] r_avail     [MAX_RESOURCES];
    logic [WW-1:0] r_work      [MAX_RESOURCES];
    logic [PW-1:0] r_order     [MAX_PROCESSES];
    logic [VW-1:0] r_max_q, r_alloc_q, r_need_q;
    logic          r_strobe;
    bsc_pkg::t_out_item r_result;

    logic              pi_ok, ri_ok;
    logic [PW+RW-1:0]  wr_addr, rd_addr;
    logic [PW+3:0]     pid_ext;
    logic [WW-1:0]     work_cur;

    assign pi_ok   = {3'b000, i_item.process_index} < 7'(MAX_PROCESSES);
    assign ri_ok   = {2'b00, i_item.resource_index} < 5'(MAX_RESOURCES);
    assign wr_addr = {PW'(i_item.process_index), RW'(i_item.resource_index)};
    assign rd_addr = {i_p_idx, i_r_idx};
    assign work_cur = r_work[i_r_idx];

    // loads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ri_ok) begin
            if (i_item.cmd == bsc_pkg::CMD_LOAD_AVAIL) begin
                r_avail[RW'(i_item.resource_index)] <= i_item.value;
            end
            if (pi_ok) begin
                if (i_item.cmd == bsc_pkg::CMD_LOAD_MAX) begin
                    r_max_mem[wr_addr] <= i_item.value;
                end
                if (i_item.cmd == bsc_pkg::CMD_LOAD_ALLOC) begin
                    r_alloc_mem[wr_addr] <= i_item.value;
                end
                if (i_item.cmd == bsc_pkg::CMD_LOAD_NEED) begin
                    r_need_mem[wr_addr] <= i_item.value;
                end
            end
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_max_q   <= r_max_mem[rd_addr];
            r_alloc_q <= r_alloc_mem[rd_addr];
            r_need_q  <= r_need_mem[rd_addr];
        end
    end

    assign o_stat.mismatch = ({1'b0, r_max_q} - {1'b0, r_alloc_q}) != {1'b0, r_need_q};
    assign o_stat.fits     = WW'(r_need_q) <= work_cur;

    // work vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_work[i] <= '0;
            end
        end else if (i_cmd.work_init) begin
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                r_work[i] <= (i < int'(i_nr)) ? WW'(r_avail[i]) : '0;
            end
        end else if (i_cmd.work_add) begin
            r_work[i_r_idx] <= work_cur + WW'(r_alloc_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.order_wr) begin
            r_order[i_slot] <= i_p_idx;
        end
    end

    assign pid_ext = {4'b0000, r_order[i_p_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.status     <= i_cmd.emit_status;
            r_result.process_id <= (i_cmd.emit_status == bsc_pkg::ST_SAFE) ?
                                   pid_ext[3:0] : 4'd0;
            r_result.last       <= i_cmd.emit_last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ design/bsc_ctrl.sv @@
module bsc_ctrl #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1,
    localparam int RCW = $clog2(MAX_RESOURCES + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [2:0]                            i_item_cmd,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  bsc_pkg::t_dp_stat                     i_stat,
    output logic                                  o_busy,
    output bsc_pkg::t_dp_cmd                      o_cmd,
    output logic [PW-1:0]                         o_p_idx,
    output logic [RW-1:0]                         o_r_idx,
    output logic [PW-1:0]                         o_slot,
    output logic [RCW-1:0]                        o_nr
);

    localparam int PCW = $clog2(MAX_PROCESSES + 1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_CON_RD   = 11'b00000000010,
        S_CON_EV   = 11'b00000000100,
        S_INIT     = 11'b00000001000,
        S_SEL      = 11'b00000010000,
        S_FIT_RD   = 11'b00000100000,
        S_FIT_EV   = 11'b00001000000,
        S_ADD_RD   = 11'b00010000000,
        S_ADD_EV   = 11'b00100000000,
        S_PASS_END = 11'b01000000000,
        S_EMIT     = 11'b10000000000
    } t_state;

    t_state               r_state, n_state;
    logic [4:0]           r_pcount;
    logic [3:0]           r_rcount;
    logic [PW-1:0]        r_p, n_p;
    logic [RW-1:0]        r_r, n_r;
    logic [PCW-1:0]       r_done, n_done;
    logic                 r_progress, n_progress;
    logic [MAX_PROCESSES-1:0] r_fin, n_fin;

    logic [PCW-1:0] np, np_m1;
    logic [RCW-1:0] nr, nr_m1;
    logic           p_last, r_last;

    // clamp counts: zero acts as one, above bound acts as bound
    always_comb begin
        if (r_pcount == 5'd0) begin
            np = PCW'(1);
        end else if ({2'b00, r_pcount} > 7'(MAX_PROCESSES)) begin
            np = PCW'(MAX_PROCESSES);
        end else begin
            np = PCW'(r_pcount);
        end
        if (r_rcount == 4'd0) begin
            nr = RCW'(1);
        end else if ({1'b0, r_rcount} > 5'(MAX_RESOURCES)) begin
            nr = RCW'(MAX_RESOURCES);
        end else begin
            nr = RCW'(r_rcount);
        end
    end

    assign np_m1  = np - PCW'(1);
    assign nr_m1  = nr - RCW'(1);
    assign p_last = PCW'(r_p) == np_m1;
    assign r_last = RCW'(r_r) == nr_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 5'd1;
            r_rcount <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsc_pkg::CFG_PROCESS_COUNT:  r_pcount <= i_cfg_data;
                bsc_pkg::CFG_RESOURCE_COUNT: r_rcount <= i_cfg_data[3:0];
                default:                     r_pcount <= r_pcount;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_r        = r_r;
        n_done     = r_done;
        n_progress = r_progress;
        n_fin      = r_fin;
        o_cmd      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_item_cmd == bsc_pkg::CMD_CHECK) begin
                        n_p     = '0;
                        n_r     = '0;
                        n_state = S_CON_RD;
                    end
                end
            end
            S_CON_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_CON_EV;
            end
            S_CON_EV: begin
                if (i_stat.mismatch) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = bsc_pkg::ST_INCONS;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end else if (r_last) begin
                    n_r = '0;
                    if (p_last) begin
                        n_state = S_INIT;
                    end else begin
                        n_p     = r_p + PW'(1);
                        n_state = S_CON_RD;
                    end
                end else begin
                    n_r     = r_r + RW'(1);
                    n_state = S_CON_RD;
                end
            end
            S_INIT: begin
                o_cmd.work_init = 1'b1;
                n_fin      = '0;
                n_done     = '0;
                n_progress = 1'b0;
                n_p        = '0;
                n_state    = S_SEL;
            end
            S_SEL: begin
                n_r = '0;
                if (!r_fin[r_p]) begin
                    n_state = S_FIT_RD;
                end else if (p_last) begin
                    n_state = S_PASS_END;
                end else begin
                    n_p = r_p + PW'(1);
                end
            end
            S_FIT_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_FIT_EV;
            end
            S_FIT_EV: begin
                if (!i_stat.fits) begin
                    if (p_last) begin
                        n_state = S_PASS_END;
                    end else begin
                        n_p     = r_p + PW'(1);
                        n_state = S_SEL;
                    end
                end else if (r_last) begin
                    n_r     = '0;
                    n_state = S_ADD_RD;
                end else begin
                    n_r     = r_r + RW'(1);
                    n_state = S_FIT_RD;
                end
            end
            S_ADD_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_ADD_EV;
            end
            S_ADD_EV: begin
                o_cmd.work_add = 1'b1;
                if (r_last) begin
                    o_cmd.order_wr = 1'b1;
                    n_fin[r_p]     = 1'b1;
                    n_done         = r_done + PCW'(1);
                    n_progress     = 1'b1;
                    if (p_last) begin
                        n_state = S_PASS_END;
                    end else begin
                        n_p     = r_p + PW'(1);
                        n_state = S_SEL;
                    end
                end else begin
                    n_r     = r_r + RW'(1);
                    n_state = S_ADD_RD;
                end
            end
            S_PASS_END: begin
                n_p = '0;
                if (r_done == np) begin
                    n_state = S_EMIT;
                end else if (r_progress) begin
                    n_progress = 1'b0;
                    n_state    = S_SEL;
                end else begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = bsc_pkg::ST_UNSAFE;
                    o_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EMIT: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = bsc_pkg::ST_SAFE;
                o_cmd.emit_last   = p_last;
                if (p_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_p = r_p + PW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_p        <= '0;
            r_r        <= '0;
            r_done     <= '0;
            r_progress <= 1'b0;
            r_fin      <= '0;
        end else begin
            r_state    <= n_state;
            r_p        <= n_p;
            r_r        <= n_r;
            r_done     <= n_done;
            r_progress <= n_progress;
            r_fin      <= n_fin;
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_p_idx = r_p;
    assign o_r_idx = r_r;
    assign o_slot  = r_done[PW-1:0];
    assign o_nr    = nr;

endmodule

@@ design/bankers_safety_check.sv @@
// Banker's algorithm safety checker.
// Command channel: an item is taken on a clock edge with start high and busy
//   low. Load commands (available, max, allocation, need) write one entry and
//   give no result, so loads stream one per cycle while busy is low.
// Check command: busy rises for the whole search. First a consistency sweep
//   over the P*R entries (P processes, R resources in use; one memory read
//   plus one compare per entry). Then an init state and the safety search:
//   a process visit has a select state, a read and fit check per resource
//   checked, and a read and work add per resource when it finishes; at most
//   P passes, each with an end state. Matrix reads are registered.
// Results: o_strobe marks a beat on o_result for exactly one cycle; the
//   receiver cannot stall. Safe gives P beats (safe order, last on the
//   final one); unsafe or inconsistent gives one beat with last set.
//   Each beat is registered from the controller's emit command.
// Config: i_cfg_we writes process_count (index 0) or resource_count (index 1)
//   at once; the user writes only while idle; the block does not enforce it.
// Reset (synchronous, active low) sets both counts to 1, clears work and
//   control; matrix contents are undefined until loaded.
module bankers_safety_check #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bsc_pkg::t_in_item               i_item,
    output logic                            o_strobe,
    output bsc_pkg::t_out_item              o_result,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int RCW = $clog2(MAX_RESOURCES + 1);

    bsc_pkg::t_dp_cmd  dp_cmd;
    bsc_pkg::t_dp_stat dp_stat;
    logic [PW-1:0]     p_idx, slot;
    logic [RW-1:0]     r_idx;
    logic [RCW-1:0]    nr;

    bsc_ctrl #(
        .MAX_PROCESSES(MAX_PROCESSES),
        .MAX_RESOURCES(MAX_RESOURCES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item_cmd (i_item.cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stat     (dp_stat),
        .o_busy     (busy),
        .o_cmd      (dp_cmd),
        .o_p_idx    (p_idx),
        .o_r_idx    (r_idx),
        .o_slot     (slot),
        .o_nr       (nr)
    );

    bsc_datapath #(
        .MAX_PROCESSES(MAX_PROCESSES),
        .MAX_RESOURCES(MAX_RESOURCES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .i_p_idx  (p_idx),
        .i_r_idx  (r_idx),
        .i_slot   (slot),
        .i_nr     (nr),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
